### rtl/cmtf_pkg.sv
// ----------------------------------------------------------------------------
// cmtf_pkg
// shared types and constants of the collinear marker triple finder
// ----------------------------------------------------------------------------
package cmtf_pkg;

  localparam int CxW  = 14;
  localparam int CyW  = 13;
  localparam int DiffW = 15;           // signed step component
  localparam int LenW  = 29;           // squared step length
  localparam int DotW  = 30;           // signed dot product

  // image geometry and centroid fixed point format
  localparam int ImageWidth   = 640;
  localparam int ImageHeight  = 480;
  localparam int FractionBits = 4;
  localparam logic [CxW-1:0] XLim = CxW'(ImageWidth * (1 << FractionBits) - 1);
  localparam logic [CyW-1:0] YLim = CyW'(ImageHeight * (1 << FractionBits) - 1);

  localparam logic [15:0] MinCosReset   = 16'd59146;
  localparam logic [17:0] MinRatioReset = 18'd65536;
  localparam logic [17:0] MaxRatioReset = 18'd128451;

  localparam logic [1:0] RegMinCos   = 2'd0;
  localparam logic [1:0] RegMinRatio = 2'd1;
  localparam logic [1:0] RegMaxRatio = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic div_start;     // start both centroid divisions
    logic store_wr;      // write divided centroid to the store
    logic eval_start;    // start evaluating current triple
  } cmtf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic eval_done;
    logic eval_pass;
  } cmtf_sts_t;

endpackage

### rtl/cmtf_ram.sv
// ----------------------------------------------------------------------------
// cmtf_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module cmtf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cmtf_div.sv
// ----------------------------------------------------------------------------
// cmtf_div
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module cmtf_div #(
  parameter int NumW = 36,
  parameter int DenW = 19,
  parameter int OutW = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [OutW-1:0] limit,
  output logic            done,
  output logic [OutW-1:0] quo
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  assign trial = {rem[DenW-1:0], q[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (!diff[DenW+1]) begin
          rem <= diff[DenW:0];
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero count gives zero; else clamp to limit
  always_comb begin
    if (d == '0) begin
      quo = '0;
    end else if (q > NumW'(limit)) begin
      quo = limit;
    end else begin
      quo = q[OutW-1:0];
    end
  end

endmodule

### rtl/cmtf_datapath.sv
// ----------------------------------------------------------------------------
// cmtf_datapath
// centroid dividers, centroid store and triple evaluation pipeline
// ----------------------------------------------------------------------------
module cmtf_datapath #(
  parameter int MaxBlobs     = 16,
  localparam int IdxW = $clog2(MaxBlobs)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmtf_pkg::cmtf_cmd_t cmd,
  output cmtf_pkg::cmtf_sts_t sts,
  input  logic [27:0]         x_moment,
  input  logic [27:0]         y_moment,
  input  logic [18:0]         pixel_count,
  input  logic [IdxW-1:0]     wr_idx,
  input  logic [IdxW-1:0]     rd_idx,
  input  logic [IdxW-1:0]     ti,
  input  logic [IdxW-1:0]     tj,
  input  logic [IdxW-1:0]     tk,
  input  logic [15:0]         min_cos_sq,
  input  logic [17:0]         min_ratio_sq,
  input  logic [17:0]         max_ratio_sq,
  output logic [13:0]         rd_x,
  output logic [12:0]         rd_y
);

  localparam int FracW = cmtf_pkg::FractionBits;
  localparam int NumW = 28 + FracW;

  logic        dx_done, dy_done;
  logic [13:0] qx;
  logic [12:0] qy;
  logic        got_x, got_y;

  cmtf_div #(.NumW(NumW), .DenW(19), .OutW(14)) u_divx (
    .clk, .rst, .start(cmd.div_start), .num({x_moment, FracW'(0)}),
    .den(pixel_count), .limit(cmtf_pkg::XLim), .done(dx_done), .quo(qx));
  cmtf_div #(.NumW(NumW), .DenW(19), .OutW(13)) u_divy (
    .clk, .rst, .start(cmd.div_start), .num({y_moment, FracW'(0)}),
    .den(pixel_count), .limit(cmtf_pkg::YLim), .done(dy_done), .quo(qy));

  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) begin
      got_x <= 1'b0;
      got_y <= 1'b0;
    end else begin
      if (dx_done) got_x <= 1'b1;
      if (dy_done) got_y <= 1'b1;
    end
  end
  assign sts.div_done = got_x && got_y;

  // evaluation sequence: read i, j, k then compute
  logic [IdxW-1:0] raddr;
  logic [13:0]     mx;
  logic [12:0]     my;
  logic [3:0]      ph;        // one-hot phase shift, bit0 = issue i
  logic [3:0]      ex;        // arithmetic stages
  logic [13:0]     xi, xj;
  logic [12:0]     yi, yj;

  always_comb begin
    raddr = rd_idx;
    if (ph[0]) raddr = ti;
    else if (ph[1]) raddr = tj;
    else if (ph[2]) raddr = tk;
  end

  cmtf_ram #(.Width(14), .Depth(MaxBlobs)) u_xs (
    .clk, .we(cmd.store_wr), .waddr(wr_idx), .wdata(qx), .raddr, .rdata(mx));
  cmtf_ram #(.Width(13), .Depth(MaxBlobs)) u_ys (
    .clk, .we(cmd.store_wr), .waddr(wr_idx), .wdata(qy), .raddr, .rdata(my));

  assign rd_x = mx;
  assign rd_y = my;

  localparam int DiffW_L = cmtf_pkg::DiffW;
  logic signed [DiffW_L-1:0] d1x, d1y, d2x, d2y;
  logic signed [cmtf_pkg::DotW-1:0] dot;
  logic [cmtf_pkg::LenW-1:0] l1, l2;
  logic [59:0] dsq;
  logic [57:0] lp;
  logic [45:0] rlo, rhi;
  logic [44:0] s2;
  logic [75:0] lhs, rhs;
  logic        pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= '0;
      ex <= '0;
    end else begin
      ph <= {ph[2:0], cmd.eval_start};
      ex <= {ex[2:0], ph[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (ph[1]) begin xi <= mx; yi <= my; end
    if (ph[2]) begin
      xj  <= mx; yj <= my;
      d1x <= DiffW_L'(signed'({1'b0, mx})) - DiffW_L'(signed'({1'b0, xi}));
      d1y <= DiffW_L'(signed'({1'b0, my})) - DiffW_L'(signed'({1'b0, yi}));
    end
    if (ph[3]) begin
      d2x <= DiffW_L'(signed'({1'b0, mx})) - DiffW_L'(signed'({1'b0, xj}));
      d2y <= DiffW_L'(signed'({1'b0, my})) - DiffW_L'(signed'({1'b0, yj}));
    end
    // stage 1: products of steps
    if (ex[0]) begin
      dot <= cmtf_pkg::DotW'(d1x * d2x) + cmtf_pkg::DotW'(d1y * d2y);
      l1  <= cmtf_pkg::LenW'(d1x * d1x) + cmtf_pkg::LenW'(d1y * d1y);
      l2  <= cmtf_pkg::LenW'(d2x * d2x) + cmtf_pkg::LenW'(d2y * d2y);
    end
    // stage 2: squares and ratio products
    if (ex[1]) begin
      pos <= dot > 0;
      dsq <= 60'(unsigned'(dot)) * 60'(unsigned'(dot));
      lp  <= 58'(l1) * 58'(l2);
      rlo <= 46'(l1) * 46'(min_ratio_sq);
      rhi <= 46'(l1) * 46'(max_ratio_sq);
      s2  <= {l2, 16'b0};
    end
    // stage 3: scale cosine side
    if (ex[2]) begin
      lhs <= {dsq, 16'b0};
      rhs <= 76'(lp) * 76'(min_cos_sq);
    end
  end

  assign sts.eval_done = ex[3];
  assign sts.eval_pass = pos && (lhs > rhs) && (46'(s2) > rlo) && (46'(s2) < rhi);

endmodule

### rtl/cmtf_ctrl.sv
// ----------------------------------------------------------------------------
// cmtf_ctrl
// sequencer: load, divide, store, triple search, result emission
// ----------------------------------------------------------------------------
module cmtf_ctrl #(
  parameter int MaxBlobs = 16,
  localparam int IdxW = $clog2(MaxBlobs),
  localparam int CntW = $clog2(MaxBlobs + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_last,
  output cmtf_pkg::cmtf_cmd_t cmd,
  input  cmtf_pkg::cmtf_sts_t sts,
  output logic [IdxW-1:0]     wr_idx,
  output logic [IdxW-1:0]     rd_idx,
  output logic [IdxW-1:0]     ti,
  output logic [IdxW-1:0]     tj,
  output logic [IdxW-1:0]     tk,
  input  logic [13:0]         rd_x,
  input  logic [12:0]         rd_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [1:0]          out_rank,
  output logic [3:0]          out_index,
  output logic [13:0]         out_x,
  output logic [12:0]         out_y,
  output logic                out_last
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_NEXT = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_RD   = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t          state;
  logic [CntW-1:0] count;
  logic            last;
  logic            found;
  logic [1:0]      rank;
  logic            started;

  logic [IdxW-1:0] n_m1;
  assign n_m1 = IdxW'(count - 1'b1);
  assign wr_idx = IdxW'(count);

  always_comb begin
    case (rank)
      2'd0:    rd_idx = ti;
      2'd1:    rd_idx = tj;
      default: rd_idx = tk;
    endcase
  end

  assign in_ready       = (state == S_IDLE);
  assign cmd.div_start  = (state == S_IDLE) && in_valid && (count < CntW'(MaxBlobs));
  assign cmd.store_wr   = (state == S_DIV) && sts.div_done;
  assign cmd.eval_start = (state == S_NEXT) && started;

  function automatic logic distinct(input logic [IdxW-1:0] a, b, c);
    distinct = (a != b) && (a != c) && (b != c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          last <= in_last;
          if (count < CntW'(MaxBlobs)) begin
            state <= S_DIV;
          end else if (in_last) begin
            state <= S_NEXT; ti <= '0; tj <= '0; tk <= '0; started <= 1'b0;
          end
        end
        S_DIV: if (sts.div_done) begin
          count <= count + 1'b1;
          if (last) begin
            state <= S_NEXT; ti <= '0; tj <= '0; tk <= '0; started <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end
        // step (ti,tj,tk) until distinct; started marks a valid triple
        S_NEXT: begin
          if (count < CntW'(3)) begin
            found <= 1'b0; state <= S_OUT;
          end else if (started) begin
            state <= S_EVAL;
          end else begin
            if (distinct(ti, tj, tk)) begin
              started <= 1'b1;
            end else if (tk != n_m1) begin
              tk <= tk + 1'b1;
            end else if (tj != n_m1) begin
              tk <= '0; tj <= tj + 1'b1;
            end else if (ti != n_m1) begin
              tk <= '0; tj <= '0; ti <= ti + 1'b1;
            end else begin
              found <= 1'b0; state <= S_OUT;
            end
          end
        end
        S_EVAL: if (sts.eval_done) begin
          if (sts.eval_pass) begin
            found <= 1'b1; rank <= 2'd0; state <= S_RD;
          end else begin
            started <= 1'b0;
            if (tk != n_m1) begin
              tk <= tk + 1'b1; state <= S_NEXT;
            end else if (tj != n_m1) begin
              tk <= '0; tj <= tj + 1'b1; state <= S_NEXT;
            end else if (ti != n_m1) begin
              tk <= '0; tj <= '0; ti <= ti + 1'b1; state <= S_NEXT;
            end else begin
              found <= 1'b0; state <= S_OUT;
            end
          end
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          out_found <= found;
          if (found) begin
            out_rank  <= rank;
            out_index <= 4'(rd_idx);
            out_x     <= rd_x;
            out_y     <= rd_y;
            out_last  <= (rank == 2'd2);
          end else begin
            out_rank <= '0; out_index <= '0; out_x <= '0; out_y <= '0;
            out_last <= 1'b1;
          end
          state <= S_WAIT;
        end
        S_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          if (out_last) begin
            count <= '0; state <= S_IDLE;
          end else begin
            rank <= rank + 1'b1; state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/collinear_marker_triple_finder_unit.sv
// ----------------------------------------------------------------------------
// collinear_marker_triple_finder_unit
// blob centroid store and collinear marker triple search
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one blob per item: moments, pixel count, tlast on the
//   last blob of a frame. each stored blob is divided by two bit-serial
//   dividers (one quotient bit per cycle), so ready drops while a blob is
//   divided; blobs past MaxBlobs are taken at once and dropped. the last
//   blob starts the triple search: the ordered triples of distinct indices
//   are evaluated one at a time, each by three store reads and a multiply
//   and compare pipe, and each index step with a repeated index is skipped,
//   up to n^3 steps for n blobs.
//   m_axis then gives three items (found, ranks 0..2) or one not-found
//   item, tlast on the final one. the output register holds while
//   m_axis_tready is low, and no new blob is taken until the frame's
//   results are gone. reset clears the blob count and the registers to
//   their defaults; the centroid store is not cleared. apb writes are
//   taken any time, pready is tied high.
// ----------------------------------------------------------------------------
module collinear_marker_triple_finder_unit #(
  parameter int MaxBlobs     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input blobs
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // x_moment, y_moment, pixel_count
  input  logic        s_axis_tlast,   // last_blob
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // rank, blob_index, centroid_x, centroid_y
  output logic        m_axis_tuser,   // found
  output logic        m_axis_tlast    // last_result
);

  localparam int IdxW = $clog2(MaxBlobs);

  logic [15:0] min_cos_sq;
  logic [17:0] min_ratio_sq, max_ratio_sq;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cos_sq   <= cmtf_pkg::MinCosReset;
      min_ratio_sq <= cmtf_pkg::MinRatioReset;
      max_ratio_sq <= cmtf_pkg::MaxRatioReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        cmtf_pkg::RegMinCos:   min_cos_sq   <= pwdata[15:0];
        cmtf_pkg::RegMinRatio: min_ratio_sq <= pwdata[17:0];
        cmtf_pkg::RegMaxRatio: max_ratio_sq <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cmtf_pkg::RegMinCos:   prdata = {16'b0, min_cos_sq};
      cmtf_pkg::RegMinRatio: prdata = {14'b0, min_ratio_sq};
      cmtf_pkg::RegMaxRatio: prdata = {14'b0, max_ratio_sq};
      default:               prdata = '0;
    endcase
  end

  cmtf_pkg::cmtf_cmd_t cmd;
  cmtf_pkg::cmtf_sts_t sts;
  logic [IdxW-1:0] wr_idx, rd_idx, ti, tj, tk;
  logic [13:0] rd_x, out_x;
  logic [12:0] rd_y, out_y;
  logic [1:0]  out_rank;
  logic [3:0]  out_index;

  cmtf_datapath #(
    .MaxBlobs(MaxBlobs)
  ) u_dp (
    .clk, .rst, .cmd, .sts,
    .x_moment(s_axis_tdata[27:0]), .y_moment(s_axis_tdata[55:28]),
    .pixel_count(s_axis_tdata[74:56]),
    .wr_idx, .rd_idx, .ti, .tj, .tk,
    .min_cos_sq, .min_ratio_sq, .max_ratio_sq, .rd_x, .rd_y
  );

  cmtf_ctrl #(.MaxBlobs(MaxBlobs)) u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_last(s_axis_tlast),
    .cmd, .sts, .wr_idx, .rd_idx, .ti, .tj, .tk, .rd_x, .rd_y,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_found(m_axis_tuser), .out_rank, .out_index, .out_x, .out_y,
    .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_y, out_x, out_index, out_rank};

endmodule
